/* sv/sorted_key_list_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key list
// Clocked concurrent assertion wrappers that compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_LIST_MACROS_SVH
`define SORTED_KEY_LIST_MACROS_SVH

`ifndef SYNTH

// Checked at every rising edge while reset is low.
`define SKL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define SKL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SKL_ASSERT(lbl, clk, rst, prop, msg)
`define SKL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/skl_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key list package
// Default sizes, command and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package skl_pkg;

   // Default sizes of the list.
   localparam int CAPACITY_DEFAULT     = 16;
   localparam int HANDLE_COUNT_DEFAULT = 64;
   localparam int KEY_BITS_DEFAULT     = 32;

   // Request commands.
   localparam logic [1:0] CMD_SORTED = 2'd0;
   localparam logic [1:0] CMD_TAIL   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_PRESENT   = 2'd3;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic ins_en;   // commit an insert this cycle
      logic rem_en;   // commit a remove this cycle
      logic sorted;   // insert by key order rather than at the tail
   } ctrl_type;

endpackage

`default_nettype wire

/* sv/skl_cell.sv */
// ----------------------------------------------------------------------------
// Sorted key list cell
// One slot of the list: holds a handle and key, compares them against the
// request, and takes data from its left or right neighbor when entries shift.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_cell
   import skl_pkg::*;
#(
   parameter int INDEX       = 0,
   parameter int HANDLE_BITS = 6,
   parameter int KEY_BITS    = 32,
   parameter int COUNT_BITS  = 5
) (
   input  wire logic                   clock,
   input  wire ctrl_type               ctrl,
   input  wire logic [COUNT_BITS-1:0]  count,
   input  wire logic [HANDLE_BITS-1:0] new_handle,
   input  wire logic [KEY_BITS-1:0]    new_key,
   input  wire logic                   left_passes,
   input  wire logic [HANDLE_BITS-1:0] left_handle,
   input  wire logic [KEY_BITS-1:0]    left_key,
   input  wire logic                   left_found,
   input  wire logic [HANDLE_BITS-1:0] right_handle,
   input  wire logic [KEY_BITS-1:0]    right_key,
   output logic                        passes,
   output logic                        match,
   output logic                        found,
   output logic [HANDLE_BITS-1:0]      handle,
   output logic [KEY_BITS-1:0]         key
);

   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic                   occupied;

   // The slot holds a live entry when it lies below the fill count.
   assign occupied = (COUNT_BITS'(INDEX) < count);
   assign match    = occupied && (handle_ff == new_handle);
   assign found    = left_found || match;

   // A new entry goes past this slot when it went past every slot to the
   // left and this slot keeps its place. The insert position is the first
   // slot that stops it, even when later keys are out of order.
   assign passes   = left_passes && occupied && (!ctrl.sorted || (key_ff <= new_key));

   assign handle = handle_ff;
   assign key    = key_ff;

   // Shift right on insert, left on remove, otherwise hold.
   always_comb begin
      handle_in = handle_ff;
      key_in    = key_ff;
      if (ctrl.ins_en && !passes) begin
         if (left_passes) begin
            handle_in = new_handle;
            key_in    = new_key;
         end else begin
            handle_in = left_handle;
            key_in    = left_key;
         end
      end else if (ctrl.rem_en && found) begin
         handle_in = right_handle;
         key_in    = right_key;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      key_ff    <= key_in;
   end

endmodule

`default_nettype wire

/* sv/sorted_key_list.sv */
// ----------------------------------------------------------------------------
// Sorted key list
// Ordered list of handles with keys, kept in a chain of compare-and-shift
// cells, with head, count and status returned for every request.
// ----------------------------------------------------------------------------
// Usage:
//   A request (command, handle, key) enters on the req_ channel; each request
//   yields exactly one result on the rsp_ channel: status, entry count after
//   the request, and the head entry (zero with head_valid low when empty).
//   Sorted inserts go after all entries with a key less than or equal to
//   theirs; tail inserts append; removes close the gap.
//   The result register loads at the edge where the request is accepted.
//   Throughput, with no result stall, is one request per cycle, set by the
//   single compare-and-shift step that every cell of the chain makes at once.
//   The insert position and the found flag for removes ripple through the
//   cells in that same cycle.
//   The result register parts the two channels: a new request is taken
//   while the previous result is being taken. When the receiver stalls, the
//   result holds and req_ready drops until it is taken.
//   Synchronous reset empties the list, drops rsp_valid and holds req_ready
//   low; slot contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_list_macros.svh"

module sorted_key_list
   import skl_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEFAULT,
   parameter int HANDLE_COUNT = HANDLE_COUNT_DEFAULT,
   parameter int KEY_BITS     = KEY_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_command,
   input  wire logic [$clog2(HANDLE_COUNT)-1:0]   req_handle,
   input  wire logic [KEY_BITS-1:0]               req_key,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_entry_count,
   output logic                                   rsp_head_valid,
   output logic [$clog2(HANDLE_COUNT)-1:0]        rsp_head_handle,
   output logic [KEY_BITS-1:0]                    rsp_head_key
);

   localparam int HANDLE_BITS = $clog2(HANDLE_COUNT);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [COUNT_BITS-1:0]  out_count_ff;
   logic                   head_valid_ff, head_valid_in;
   logic [HANDLE_BITS-1:0] head_handle_ff, head_handle_in;
   logic [KEY_BITS-1:0]    head_key_ff, head_key_in;

   logic                   accept;
   logic                   full;
   ctrl_type               ctrl;

   logic [CAPACITY-1:0]    passes;
   logic [CAPACITY-1:0]    match;
   logic [CAPACITY:0]      found;
   logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
   logic [KEY_BITS-1:0]    cell_key    [CAPACITY];

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == COUNT_BITS'(CAPACITY));
   assign found[0]  = 1'b0;

   // Cell chain: each cell sees its left and right neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                   lp;
      logic [HANDLE_BITS-1:0] lh, rh;
      logic [KEY_BITS-1:0]    lk, rk;

      if (i == 0) begin : g_left_edge
         assign lp = 1'b1;
         assign lh = req_handle;
         assign lk = req_key;
      end else begin : g_left
         assign lp = passes[i-1];
         assign lh = cell_handle[i-1];
         assign lk = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_right_edge
         assign rh = cell_handle[i];
         assign rk = cell_key[i];
      end else begin : g_right
         assign rh = cell_handle[i+1];
         assign rk = cell_key[i+1];
      end

      skl_cell #(
         .INDEX       (i),
         .HANDLE_BITS (HANDLE_BITS),
         .KEY_BITS    (KEY_BITS),
         .COUNT_BITS  (COUNT_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .count        (count_ff),
         .new_handle   (req_handle),
         .new_key      (req_key),
         .left_passes  (lp),
         .left_handle  (lh),
         .left_key     (lk),
         .left_found   (found[i]),
         .right_handle (rh),
         .right_key    (rk),
         .passes       (passes[i]),
         .match        (match[i]),
         .found        (found[i+1]),
         .handle       (cell_handle[i]),
         .key          (cell_key[i])
      );
   end

   // Command decode: status, commit strobes and the new count.
   always_comb begin
      status_in   = ST_OK;
      ctrl        = '0;
      ctrl.sorted = (req_command == CMD_SORTED);
      count_in    = count_ff;
      unique case (req_command) inside
         CMD_SORTED, CMD_TAIL: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (found[CAPACITY]) begin
               status_in = ST_PRESENT;
            end else begin
               ctrl.ins_en = accept;
               if (accept) count_in = count_ff + COUNT_BITS'(1);
            end
         end
         CMD_REMOVE: begin
            if (found[CAPACITY]) begin
               ctrl.rem_en = accept;
               if (accept) count_in = count_ff - COUNT_BITS'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Head of the list after this request.
   always_comb begin
      head_handle_in = cell_handle[0];
      head_key_in    = cell_key[0];
      if (ctrl.ins_en && !passes[0]) begin
         head_handle_in = req_handle;
         head_key_in    = req_key;
      end else if (ctrl.rem_en && match[0]) begin
         head_handle_in = cell_handle[1];
         head_key_in    = cell_key[1];
      end
      head_valid_in = (count_in != '0);
      if (!head_valid_in) begin
         head_handle_in = '0;
         head_key_in    = '0;
      end
   end

   // Result register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads with each accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         out_count_ff   <= count_in;
         head_valid_ff  <= head_valid_in;
         head_handle_ff <= head_handle_in;
         head_key_ff    <= head_key_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_head_valid  = head_valid_ff;
   assign rsp_head_handle = head_handle_ff;
   assign rsp_head_key    = head_key_ff;

   // Reset empties the list and clears any pending result.
   `SKL_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid_ff && (count_ff == '0), "reset did not clear list")

   // The fill count never passes the capacity.
   `SKL_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_BITS'(CAPACITY), "count over capacity")

   // A refused request leaves the list size unchanged.
   `SKL_ASSERT(a_refused_hold, clock, reset, accept && (status_in != ST_OK) |=> count_ff == $past(count_ff), "refused request changed count")

   // A successful remove shrinks the list by one.
   `SKL_ASSERT(a_remove_dec, clock, reset, accept && (req_command == CMD_REMOVE) && found[CAPACITY] |=> count_ff == $past(count_ff) - COUNT_BITS'(1), "remove did not shrink list")

   // A result reports a head exactly when it reports entries.
   `SKL_ASSERT(a_head_flag, clock, reset, rsp_valid_ff |-> head_valid_ff == (out_count_ff != '0), "head flag disagrees with count")

endmodule

`default_nettype wire
